### hw/rtl/spd_pkg.sv
// Shared types and constants of the slice permutation descrambler.
`timescale 1ns / 1ps
package spd_pkg;

    localparam int unsigned DEF_MAX_CHUNK_BYTES = 2097152;
    localparam int unsigned DEF_SIZE_BITS       = 24;

    localparam int unsigned CFG_BITS    = 24;
    localparam int unsigned WORD_BITS   = 64;
    localparam int unsigned VB_BITS     = 4;
    localparam int unsigned TBL_AW      = 16;
    localparam int unsigned TBL_DEPTH   = 65536;
    localparam int unsigned TAG_BITS    = 16;
    localparam int unsigned SLICE_BYTES = 32;

    localparam logic [31:0] LCG_MUL  = 32'd2109;
    localparam logic [31:0] LCG_INC  = 32'd9273;
    localparam logic [15:0] RAND_OFS = 16'hc000;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_SHRINK = 8'b00000010,
        ST_RAND   = 8'b00000100,
        ST_PART   = 8'b00001000,
        ST_READ   = 8'b00010000,
        ST_SWAP   = 8'b00100000,
        ST_EMIT   = 8'b01000000,
        ST_CLEAR  = 8'b10000000
    } t_state;

    typedef struct packed {
        logic                 avail;
        logic [WORD_BITS-1:0] word;
    } t_word_q;

endpackage

### hw/rtl/spd_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module spd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

### hw/rtl/spd_front.sv
// Front end: two-entry queue of incoming source words.
`timescale 1ns / 1ps
module spd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [spd_pkg::WORD_BITS-1:0] i_word,
    output logic                         o_full,
    output spd_pkg::t_word_q             o_head,
    input  logic                         i_take
);
    logic [spd_pkg::WORD_BITS-1:0] r_buf [2];
    logic       r_rd, n_rd;
    logic       r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_take;

    assign o_full      = (r_cnt == 2'd2);
    assign w_push      = i_push && !o_full;
    assign w_take      = i_take && (r_cnt != 2'd0);
    assign o_head.avail = (r_cnt != 2'd0);
    assign o_head.word  = r_buf[r_rd];

    always_comb begin
        n_rd  = w_take ? ~r_rd : r_rd;
        n_wr  = w_push ? ~r_wr : r_wr;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_buf[r_wr] <= i_word;
        end
    end
endmodule

### hw/rtl/spd_back.sv
// Back end: slice sequencer, LCG, tagged slice table and result register.
`timescale 1ns / 1ps
module spd_back #(
    parameter int unsigned MAX_CHUNK_BYTES = spd_pkg::DEF_MAX_CHUNK_BYTES,
    parameter int unsigned SIZE_BITS       = spd_pkg::DEF_SIZE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [spd_pkg::CFG_BITS-1:0]  i_total_size,
    input  logic                          i_cfg_we,
    input  spd_pkg::t_word_q              i_head,
    output logic                          o_take,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic [spd_pkg::WORD_BITS-1:0] o_out_word,
    output logic [spd_pkg::CFG_BITS-1:0]  o_dest_addr,
    output logic [spd_pkg::VB_BITS-1:0]   o_valid_bytes,
    output logic                          o_last_word
);
    localparam int unsigned CW  = $clog2(MAX_CHUNK_BYTES) + 1;
    localparam int unsigned AW  = spd_pkg::TBL_AW;
    localparam int unsigned TW  = spd_pkg::TAG_BITS;
    localparam int unsigned EW  = AW + TW;

    spd_pkg::t_state r_state, n_state;
    logic            r_started, n_started;
    logic [15:0]     r_seed, n_seed;
    logic [15:0]     r_rand, n_rand;
    logic [AW-1:0]   r_part, n_part;
    logic [SIZE_BITS-1:0] r_bleft, n_bleft;
    logic [SIZE_BITS-1:0] r_base, n_base;
    logic [CW-1:0]   r_chunk, n_chunk;
    logic [AW-1:0]   r_spos, n_spos;
    logic [1:0]      r_wis, n_wis;
    logic [AW-1:0]   r_cur, n_cur;
    logic [TW-1:0]   r_gen, n_gen;

    logic            r_ovalid, n_ovalid;
    logic [spd_pkg::WORD_BITS-1:0] r_oword, n_oword;
    logic [spd_pkg::CFG_BITS-1:0]  r_odest, n_odest;
    logic [spd_pkg::VB_BITS-1:0]   r_ovb, n_ovb;
    logic            r_olast, n_olast;

    logic [EW-1:0]   w_rd_i, w_rd_x;
    logic            w_we;
    logic [EW-1:0]   w_wdata;
    logic [AW-1:0]   w_val_i, w_val_x;
    logic [31:0]     w_chunk32, w_bleft32, w_base32, w_total32, w_dest32, w_tmp32;
    logic [31:0]     w_lcg, w_prod, w_rem;
    logic            w_slice_mode, w_can_out;

    spd_ram #(.WIDTH(EW), .DEPTH(spd_pkg::TBL_DEPTH)) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_part),
        .i_wdata   (w_wdata),
        .i_raddr_a (r_spos),
        .i_raddr_b (r_part),
        .o_rdata_a (w_rd_i),
        .o_rdata_b (w_rd_x)
    );

    // Stale tag means the entry still holds identity for this chunk.
    assign w_val_i = (w_rd_i[EW-1:AW] == r_gen) ? w_rd_i[AW-1:0] : r_spos;
    assign w_val_x = (w_rd_x[EW-1:AW] == r_gen) ? w_rd_x[AW-1:0] : r_part;
    assign w_we    = (r_state == spd_pkg::ST_SWAP) || (r_state == spd_pkg::ST_CLEAR);
    // Sweep writes tag zero, which no chunk ever uses.
    assign w_wdata = (r_state == spd_pkg::ST_CLEAR) ? '0 : {r_gen, w_val_i};

    assign w_lcg  = 32'(r_seed) * spd_pkg::LCG_MUL + spd_pkg::LCG_INC;
    assign w_prod = 32'(r_rand) * 32'(r_spos);

    always_comb begin
        w_chunk32 = '0;
        w_chunk32[CW-1:0] = r_chunk;
        w_bleft32 = '0;
        w_bleft32[SIZE_BITS-1:0] = r_bleft;
        w_base32 = '0;
        w_base32[SIZE_BITS-1:0] = r_base;
        w_total32 = 32'(i_total_size);
    end

    assign w_slice_mode = (w_chunk32 >= 32'(spd_pkg::SLICE_BYTES));
    assign w_can_out    = !r_ovalid || i_pop;

    always_comb begin
        n_state   = r_state;
        n_started = r_started;
        n_seed    = r_seed;
        n_rand    = r_rand;
        n_part    = r_part;
        n_bleft   = r_bleft;
        n_base    = r_base;
        n_chunk   = r_chunk;
        n_spos    = r_spos;
        n_wis     = r_wis;
        n_cur     = r_cur;
        n_gen     = r_gen;
        n_ovalid  = r_ovalid && !i_pop;
        n_oword   = r_oword;
        n_odest   = r_odest;
        n_ovb     = r_ovb;
        n_olast   = r_olast;
        o_take    = 1'b0;
        w_dest32  = '0;
        w_tmp32   = '0;
        w_rem     = '0;

        case (r_state)
            spd_pkg::ST_CLEAR: begin
                n_part = r_part + AW'(1);
                if (r_part == '1) begin
                    n_gen   = TW'(1);
                    n_state = spd_pkg::ST_IDLE;
                end
            end
            spd_pkg::ST_IDLE: begin
                if (i_head.avail) begin
                    if (!r_started) begin
                        if (w_total32[SIZE_BITS-1:0] == '0) begin
                            o_take = 1'b1;
                        end else begin
                            n_seed    = i_total_size[15:0];
                            n_bleft   = w_total32[SIZE_BITS-1:0];
                            n_base    = '0;
                            n_chunk   = CW'(MAX_CHUNK_BYTES);
                            n_started = 1'b1;
                            n_state   = spd_pkg::ST_SHRINK;
                        end
                    end else if (w_slice_mode && r_wis == 2'd0) begin
                        n_state = spd_pkg::ST_RAND;
                    end else begin
                        n_state = spd_pkg::ST_EMIT;
                    end
                end
            end
            spd_pkg::ST_SHRINK: begin
                if (w_slice_mode && w_chunk32 > w_bleft32) begin
                    n_chunk = r_chunk >> 1;
                end else begin
                    n_wis   = 2'd0;
                    n_state = spd_pkg::ST_IDLE;
                    if (w_slice_mode) begin
                        w_tmp32 = (w_chunk32 >> 5) - 32'd1;
                        n_spos  = w_tmp32[AW-1:0];
                        n_gen   = r_gen + TW'(1);
                        // Tag space used up: sweep the table before reusing tags.
                        if (r_gen == '1) begin
                            n_part  = '0;
                            n_state = spd_pkg::ST_CLEAR;
                        end
                    end
                end
            end
            spd_pkg::ST_RAND: begin
                n_seed  = {1'b0, w_lcg[14:0]};
                n_rand  = {1'b0, w_lcg[14:0]} + spd_pkg::RAND_OFS;
                n_state = spd_pkg::ST_PART;
            end
            spd_pkg::ST_PART: begin
                n_part  = w_prod[31:16];
                n_state = spd_pkg::ST_READ;
            end
            spd_pkg::ST_READ: begin
                n_state = spd_pkg::ST_SWAP;
            end
            spd_pkg::ST_SWAP: begin
                n_cur   = w_val_x;
                n_state = spd_pkg::ST_EMIT;
            end
            spd_pkg::ST_EMIT: begin
                if (w_can_out) begin
                    o_take   = 1'b1;
                    n_ovalid = 1'b1;
                    n_oword  = i_head.word;
                    n_ovb    = spd_pkg::VB_BITS'(8);
                    n_olast  = 1'b0;
                    n_state  = spd_pkg::ST_IDLE;
                    if (w_slice_mode) begin
                        w_dest32 = w_base32 + (32'(r_cur) << 5) + (32'(r_wis) << 3);
                        n_wis    = r_wis + 2'd1;
                        if (r_wis == 2'd3) begin
                            if (r_spos == '0) begin
                                w_tmp32 = w_base32 + w_chunk32;
                                n_base  = w_tmp32[SIZE_BITS-1:0];
                                w_tmp32 = w_bleft32 - w_chunk32;
                                n_bleft = w_tmp32[SIZE_BITS-1:0];
                                if (w_tmp32[SIZE_BITS-1:0] == '0) begin
                                    n_olast   = 1'b1;
                                    n_started = 1'b0;
                                end else begin
                                    n_state = spd_pkg::ST_SHRINK;
                                end
                            end else begin
                                n_spos = r_spos - AW'(1);
                            end
                        end
                    end else begin
                        w_dest32 = w_base32 + (32'(r_wis) << 3);
                        w_rem    = w_bleft32 - (32'(r_wis) << 3);
                        if (w_rem <= 32'd8) begin
                            n_ovb     = w_rem[spd_pkg::VB_BITS-1:0];
                            n_olast   = 1'b1;
                            n_started = 1'b0;
                        end else begin
                            n_wis = r_wis + 2'd1;
                        end
                    end
                    w_tmp32 = '0;
                    w_tmp32[SIZE_BITS-1:0] = w_dest32[SIZE_BITS-1:0];
                    n_odest = w_tmp32[spd_pkg::CFG_BITS-1:0];
                end
            end
            default: begin
                n_state = spd_pkg::ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_started = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= spd_pkg::ST_CLEAR;
            r_started <= 1'b0;
            r_seed    <= '0;
            r_part    <= '0;
            r_bleft   <= '0;
            r_base    <= '0;
            r_chunk   <= CW'(MAX_CHUNK_BYTES);
            r_spos    <= '0;
            r_wis     <= '0;
            r_gen     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_seed    <= n_seed;
            r_part    <= n_part;
            r_bleft   <= n_bleft;
            r_base    <= n_base;
            r_chunk   <= n_chunk;
            r_spos    <= n_spos;
            r_wis     <= n_wis;
            r_gen     <= n_gen;
            r_ovalid  <= n_ovalid;
        end
        r_rand  <= n_rand;
        r_cur   <= n_cur;
        r_oword <= n_oword;
        r_odest <= n_odest;
        r_ovb   <= n_ovb;
        r_olast <= n_olast;
    end

    assign o_empty       = !r_ovalid;
    assign o_out_word    = r_oword;
    assign o_dest_addr   = r_odest;
    assign o_valid_bytes = r_ovb;
    assign o_last_word   = r_olast;
endmodule

### hw/rtl/slice_permutation_descrambler_top.sv
// Top level of the slice permutation descrambler.
// Usage:
//  - Write the image length through i_cfg_wr_en / i_cfg_wr_data while the
//    block is idle; the write also abandons any image in progress.
//  - Push scrambled words (eight bytes, first byte low) with i_push while
//    o_full is low. A two-entry input queue decouples the producer.
//  - Each word comes back unchanged with its byte address in the descrambled
//    image, its count of meaningful bytes and a mark on the final word of the
//    image. Take it with i_pop while o_empty is low.
//  - Each word inside a slice passes the sequencer states IDLE and EMIT; the
//    first word of each 32-byte slice also passes RAND, PART, READ and SWAP
//    for the LCG multiply, the partner multiply and the registered read of
//    the slice table. A new chunk adds SHRINK, which halves the chunk size.
//  - The slice table tags each entry with its chunk, so a stale tag reads as
//    identity. After reset, and again before one chunk in every 65535, a
//    sweep through all 65536 entries clears all tags; input waits meanwhile.
//  - Reset empties both queues and ends any image.
//  - When the receiver stalls, the result register holds, the sequencer
//    waits and the input queue fills and raises o_full.
//  - With an image length of zero, input words are dropped.
`timescale 1ns / 1ps
module slice_permutation_descrambler_top #(
    parameter int unsigned MAX_CHUNK_BYTES = spd_pkg::DEF_MAX_CHUNK_BYTES,
    parameter int unsigned SIZE_BITS       = spd_pkg::DEF_SIZE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_source_word,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [63:0] o_out_word,
    output logic [23:0] o_dest_addr,
    output logic [3:0]  o_valid_bytes,
    output logic        o_last_word
);
    // Hold the image length.
    logic [spd_pkg::CFG_BITS-1:0] r_total_size;
    spd_pkg::t_word_q             w_head;
    logic                         w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_size <= '0;
        end else if (i_cfg_wr_en) begin
            r_total_size <= i_cfg_wr_data;
        end
    end

    spd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_word  (i_source_word),
        .o_full  (o_full),
        .o_head  (w_head),
        .i_take  (w_take)
    );

    spd_back #(
        .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES),
        .SIZE_BITS       (SIZE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_total_size  (r_total_size),
        .i_cfg_we      (i_cfg_wr_en),
        .i_head        (w_head),
        .o_take        (w_take),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_out_word    (o_out_word),
        .o_dest_addr   (o_dest_addr),
        .o_valid_bytes (o_valid_bytes),
        .o_last_word   (o_last_word)
    );

    // Word addresses are always eight-byte aligned.
    a_dest_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_dest_addr[2:0] == 3'b000))
        else $error("destination address not word aligned");

    // A short word only ever ends the image.
    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_valid_bytes != 4'd8) |-> o_last_word)
        else $error("partial word that is not the last");

    // Byte count stays within one word.
    a_vb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_valid_bytes != 4'd0 && o_valid_bytes <= 4'd8))
        else $error("byte count out of range");
endmodule
